>>> rtl/core/base64_line_wrapped_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// base64 line-wrapped encoder assertion macros
// shared concurrent assertion forms, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef BASE64_LINE_WRAPPED_ENCODER_TOP_DEFINES_SVH
`define BASE64_LINE_WRAPPED_ENCODER_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define B64W_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define B64W_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define B64W_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/b64w_pkg.sv
// ----------------------------------------------------------------------------
// b64w_pkg
// types, constants and the symbol table of the base64 line-wrapped encoder
// ----------------------------------------------------------------------------
package b64w_pkg;

  localparam int LINE_COLS_DEF  = 76;
  localparam int LINE_POS_W     = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_PAD     = 8'd61;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  typedef logic [7:0] char_t;

  // one encoded group of four characters
  typedef struct packed {
    char_t [3:0] chars;
    logic        last;
  } group_t;

  // standard alphabet A-Z a-z 0-9 + /
  function automatic char_t sextet_char(input logic [5:0] v);
    char_t c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/b64w_front.sv
// ----------------------------------------------------------------------------
// b64w_front
// accepts message bytes, holds up to two, and builds a four-character group
// on every third byte or on the final byte
// ----------------------------------------------------------------------------
`include "base64_line_wrapped_encoder_top_defines.svh"

module b64w_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_final_byte,
  input  logic              q_full,
  output logic              q_push,
  output b64w_pkg::group_t  q_wdata
);

  logic [7:0] held_r [2];
  logic [1:0] held_cnt_r;
  logic [1:0] held_cnt_nxt;
  logic       take;
  logic       hold;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign hold     = !in_final_byte && !held_cnt_r[1];
  assign q_push   = take && !hold;

  always_comb begin
    held_cnt_nxt = held_cnt_r;
    if (take) begin
      held_cnt_nxt = hold ? (held_cnt_r + 2'd1) : 2'd0;
    end
  end

  always_comb begin
    b0 = 8'd0;
    b1 = 8'd0;
    b2 = 8'd0;
    case (held_cnt_r)
      2'd0: begin
        b0 = in_data_byte;
      end
      2'd1: begin
        b0 = held_r[0];
        b1 = in_data_byte;
      end
      default: begin
        b0 = held_r[0];
        b1 = held_r[1];
        b2 = in_data_byte;
      end
    endcase
  end

  always_comb begin
    q_wdata.chars[0] = b64w_pkg::sextet_char(b0[7:2]);
    q_wdata.chars[1] = b64w_pkg::sextet_char({b0[1:0], b1[7:4]});
    q_wdata.chars[2] = (held_cnt_r == 2'd0) ? b64w_pkg::CHAR_PAD
                                            : b64w_pkg::sextet_char({b1[3:0], b2[7:6]});
    q_wdata.chars[3] = held_cnt_r[1] ? b64w_pkg::sextet_char(b2[5:0]) : b64w_pkg::CHAR_PAD;
    q_wdata.last     = in_final_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hold) begin
      held_r[held_cnt_r[0]] <= in_data_byte;
    end
  end

  `B64W_ASSERT_ALWAYS(a_held_cnt_max, held_cnt_r != 2'd3, "held byte count above two")
  `B64W_ASSERT_NEXT(a_final_clears, take && in_final_byte, held_cnt_r == 2'd0,
                    "held bytes kept after final byte")

endmodule

>>> rtl/core/b64w_queue.sv
// ----------------------------------------------------------------------------
// b64w_queue
// short group queue between front and back
// ----------------------------------------------------------------------------
`include "base64_line_wrapped_encoder_top_defines.svh"

module b64w_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64w_pkg::group_t  wdata,
  output logic              full,
  input  logic              pop,
  output logic              rvalid,
  output b64w_pkg::group_t  rdata
);

  b64w_pkg::group_t                  entry_r [b64w_pkg::QUEUE_DEPTH];
  logic [b64w_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [b64w_pkg::QPTR_W-1:0]       wr_ptr_nxt;
  logic [b64w_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [b64w_pkg::QPTR_W-1:0]       rd_ptr_nxt;
  logic [b64w_pkg::QCNT_W-1:0]       cnt_r;
  logic [b64w_pkg::QCNT_W-1:0]       cnt_nxt;
  logic                              do_pop;

  localparam logic [b64w_pkg::QPTR_W-1:0] PtrLast = b64w_pkg::QPTR_W'(b64w_pkg::QUEUE_DEPTH - 1);
  localparam logic [b64w_pkg::QCNT_W-1:0] CntFull = b64w_pkg::QCNT_W'(b64w_pkg::QUEUE_DEPTH);

  assign full   = (cnt_r == CntFull);
  assign rvalid = (cnt_r != '0);
  assign rdata  = entry_r[rd_ptr_r];
  assign do_pop = pop && rvalid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  `B64W_ASSERT_IMPLIES(a_no_push_full, push, !full, "group pushed into full queue")

endmodule

>>> rtl/core/b64w_back.sv
// ----------------------------------------------------------------------------
// b64w_back
// emits queued groups one character per cycle, unless the output stalls, with line wrapping
// ----------------------------------------------------------------------------
`include "base64_line_wrapped_encoder_top_defines.svh"

module b64w_back #(
  parameter int LINE_COLS = b64w_pkg::LINE_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              grp_valid,
  input  b64w_pkg::group_t  grp,
  output logic              grp_pop,
  output logic              out_vld,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              out_end_of_run,
  output logic              out_end_of_message
);

  localparam logic [b64w_pkg::LINE_POS_W-1:0] LineFull = b64w_pkg::LINE_POS_W'(LINE_COLS);

  logic [1:0]                        idx_r;
  logic [1:0]                        idx_nxt;
  logic [b64w_pkg::LINE_POS_W-1:0]   line_pos_r;
  logic [b64w_pkg::LINE_POS_W-1:0]   line_pos_nxt;
  logic                              out_vld_r;
  logic                              out_vld_nxt;
  logic [7:0]                        out_char_r;
  logic [7:0]                        out_char_nxt;
  logic                              out_eor_r;
  logic                              out_eor_nxt;
  logic                              out_eom_r;
  logic                              out_eom_nxt;
  logic                              load;
  logic                              wrap;
  logic                              grp_end;

  assign load    = grp_valid && (!out_vld_r || out_ready);
  assign wrap    = (line_pos_r >= LineFull);
  assign grp_end = (idx_r == 2'd3);

  always_comb begin
    idx_nxt       = idx_r;
    line_pos_nxt  = line_pos_r;
    out_char_nxt  = out_char_r;
    out_eor_nxt   = out_eor_r;
    out_eom_nxt   = out_eom_r;
    out_vld_nxt   = out_ready ? 1'b0 : out_vld_r;
    grp_pop       = 1'b0;
    if (load) begin
      out_vld_nxt = 1'b1;
      if (wrap) begin
        out_char_nxt = b64w_pkg::CHAR_NEWLINE;
        out_eor_nxt  = 1'b0;
        out_eom_nxt  = 1'b0;
        line_pos_nxt = '0;
      end else begin
        out_char_nxt = grp.chars[idx_r];
        out_eor_nxt  = grp_end;
        out_eom_nxt  = grp_end && grp.last;
        idx_nxt      = idx_r + 2'd1;
        line_pos_nxt = (grp_end && grp.last) ? '0 : line_pos_r + 1'b1;
        grp_pop      = grp_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      line_pos_r  <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      line_pos_r  <= line_pos_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_eor_r  <= out_eor_nxt;
    out_eom_r  <= out_eom_nxt;
  end

  assign out_vld            = out_vld_r;
  assign out_char           = out_char_r;
  assign out_end_of_run     = out_eor_r;
  assign out_end_of_message = out_eom_r;

  `B64W_ASSERT_ALWAYS(a_line_pos_max, line_pos_r <= LineFull, "line position past line width")
  `B64W_ASSERT_IMPLIES(a_eom_ends_run, out_vld_r && out_eom_r, out_eor_r,
                       "message end without run end")
  `B64W_ASSERT_IMPLIES(a_newline_mid_run,
                       out_vld_r && (out_char_r == b64w_pkg::CHAR_NEWLINE), !out_eor_r,
                       "newline closes a run")

endmodule

>>> rtl/core/base64_line_wrapped_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder_top
// base64 encoder with newline insertion every LINE_COLS characters
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the two-entry group queue has room; every
// third byte, or the final byte, turns into a group of four characters. The
// output stage sends one character per cycle unless out_ready stalls it, so a group
// gives four characters, or five when a newline is inserted, and the sustained
// byte rate is set by the single-character output register.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder_top #(
  parameter int LINE_COLS = b64w_pkg::LINE_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_vld,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_end_of_run,
  output logic        out_end_of_message
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_rvalid;
  b64w_pkg::group_t  q_wdata;
  b64w_pkg::group_t  q_rdata;

  b64w_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  b64w_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_rvalid),
    .rdata  (q_rdata)
  );

  b64w_back #(
    .LINE_COLS (LINE_COLS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .grp_valid          (q_rvalid),
    .grp                (q_rdata),
    .grp_pop            (q_pop),
    .out_vld            (out_vld),
    .out_ready          (out_ready),
    .out_char           (out_char),
    .out_end_of_run     (out_end_of_run),
    .out_end_of_message (out_end_of_message)
  );

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// base64 line-wrapped encoder testbench
// Feeds whole messages byte by byte and predicts every character. Each output
// transaction is checked against the oldest expected character, its end-of-run
// flag and its end-of-message flag. Both handshakes idle at random, and the
// sender sometimes holds off until the output has drained. A short directed
// set comes first, then random messages; long ones cross the line wrap.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WRAP_COLS = b64w_pkg::LINE_COLS_DEF;
  localparam int DIRECTED_BYTES = 24;
  localparam int TOTAL_BYTES = 430;
  localparam int SETTLE_CYCLES = 20;

  typedef logic [7:0] msg_t[$];

  typedef struct {
    b64w_pkg::char_t ch;
    logic            eor;
    logic            eom;
  } enc_char_t;

  class encoded_text_board;
    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [7:0] held[2];
    int held_cnt;
    int line_pos;
    enc_char_t expected_chars[$];
    int failures;

    function new();
      held_cnt = 0;
      line_pos = 0;
      failures = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function b64w_pkg::char_t sextet(logic [5:0] v);
      return b64w_pkg::char_t'(alphabet[int'(v)]);
    endfunction

    // predict the characters caused by one accepted byte
    function void take_byte(logic [7:0] b, logic fin);
      logic [7:0] b0, b1, b2;
      b64w_pkg::char_t grp[4];
      enc_char_t one_run[$];
      enc_char_t e;
      int used;
      if (!fin && held_cnt < 2) begin
        held[held_cnt] = b;
        held_cnt++;
        return;
      end
      b0 = '0;
      b1 = '0;
      b2 = '0;
      if (held_cnt == 0) begin
        b0 = b;
      end else if (held_cnt == 1) begin
        b0 = held[0];
        b1 = b;
      end else begin
        b0 = held[0];
        b1 = held[1];
        b2 = b;
      end
      used = held_cnt + 1;
      grp[0] = sextet(b0[7:2]);
      grp[1] = sextet({b0[1:0], b1[7:4]});
      grp[2] = (used > 1) ? sextet({b1[3:0], b2[7:6]}) : b64w_pkg::CHAR_PAD;
      grp[3] = (used > 2) ? sextet(b2[5:0]) : b64w_pkg::CHAR_PAD;
      for (int i = 0; i < 4; i++) begin
        if (line_pos >= WRAP_COLS) begin
          e = '{b64w_pkg::CHAR_NEWLINE, 1'b0, 1'b0};
          one_run.push_back(e);
          line_pos = 0;
        end
        e = '{grp[i], 1'b0, 1'b0};
        one_run.push_back(e);
        line_pos++;
      end
      held_cnt = 0;
      one_run[one_run.size() - 1].eor = 1'b1;
      if (fin) begin
        one_run[one_run.size() - 1].eom = 1'b1;
        line_pos = 0;
      end
      foreach (one_run[i]) expected_chars.push_back(one_run[i]);
    endfunction

    function void match_char(b64w_pkg::char_t ch, logic eor, logic eom);
      enc_char_t e;
      if (expected_chars.size() == 0) begin
        $error("out_char: unexpected transaction, got %0d", ch);
        failures++;
        return;
      end
      e = expected_chars.pop_front();
      if (ch !== e.ch) begin
        $error("out_char: expected %0d, got %0d", e.ch, ch);
        failures++;
      end
      if (eor !== e.eor) begin
        $error("out_end_of_run: expected %0b, got %0b", e.eor, eor);
        failures++;
      end
      if (eom !== e.eom) begin
        $error("out_end_of_message: expected %0b, got %0b", e.eom, eom);
        failures++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_data_byte;
  logic            in_final_byte;
  logic            out_vld;
  logic            out_ready;
  b64w_pkg::char_t out_char;
  logic            out_end_of_run;
  logic            out_end_of_message;

  encoded_text_board board = new();
  int tx_calm = 0;
  int rx_calm = 0;

  base64_line_wrapped_encoder_top #(
    .LINE_COLS(WRAP_COLS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_final_byte(in_final_byte),
    .out_vld(out_vld),
    .out_ready(out_ready),
    .out_char(out_char),
    .out_end_of_run(out_end_of_run),
    .out_end_of_message(out_end_of_message)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // idle cycles for one transaction, with occasional stretches of none
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 30);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap(tx_calm);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    board.take_byte(b, fin);
  endtask

  task automatic send_message(input msg_t msg);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_message(input int len);
    msg_t msg;
    for (int i = 0; i < len; i++) msg.push_back(8'($urandom_range(0, 255)));
    send_message(msg);
  endtask

  // output side
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = pick_gap(rx_calm);
      @(negedge clk);
      repeat (gap) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_vld);
      board.match_char(out_char, out_end_of_run, out_end_of_message);
    end
  end

  // stimulus
  initial begin
    int sent;
    int len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_final_byte = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short groups, extremes, full groups and multi-group messages
    send_message('{8'h00});
    send_message('{8'hff});
    send_message('{8'h00, 8'hff});
    send_message('{8'hff, 8'hff});
    send_message('{8'h00, 8'h00, 8'h00});
    send_message('{8'hff, 8'hff, 8'hff});
    send_message('{8'hfb, 8'hef, 8'hbe});
    send_message('{8'h55, 8'haa, 8'h55, 8'haa});
    send_message('{8'h01, 8'h80, 8'h7f, 8'hfe, 8'h10});
    hold_until_drained();

    sent = DIRECTED_BYTES;
    len = $urandom_range(60, 160);
    send_random_message(len);
    sent += len;
    while (sent < TOTAL_BYTES) begin
      if ($urandom_range(0, 9) < 3) len = $urandom_range(57, 130);
      else len = $urandom_range(1, 12);
      if (len > TOTAL_BYTES - sent) len = TOTAL_BYTES - sent;
      send_random_message(len);
      sent += len;
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/b64w_pkg.sv
rtl/core/b64w_front.sv
rtl/core/b64w_queue.sv
rtl/core/b64w_back.sv
rtl/core/base64_line_wrapped_encoder_top.sv
dv/testbench.sv
